// ===== rtl/lkc_pkg.sv =====
// ============================================================================
// lkc_pkg: shared types and constants of the LRU key cache
// Widths, command codes, register map and the request/result structs.
// ============================================================================
package lkc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int LIM_W    = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PADDR_W-3:0] REG_MAX_ENTRIES = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_lkc_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_lkc_req;

    typedef struct packed {
        logic             ok;
        logic             evicted;
        logic [CNT_W-1:0] count;
    } t_lkc_res;

endpackage

// ===== rtl/lkc_if.sv =====
// ============================================================================
// lkc_if: request and response channels of the LRU key cache
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface lkc_in_if import lkc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [KEY_W-1:0]  key;
    logic [DATA_W-1:0]        data_value;

    modport source (output valid, output command, output key, output data_value,
                    input ready);
    modport sink   (input valid, input command, input key, input data_value,
                    output ready);
endinterface

interface lkc_out_if import lkc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic             evicted;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;

    modport source (output valid, output ok, output evicted, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input ok, input evicted, input entry_count,
                    input is_empty, output ready);
endinterface

// ===== rtl/lkc_store.sv =====
// ============================================================================
// lkc_store: entry store with parallel key match and recency ranks
// Evaluates one request against all entries and commits it on i_go.
// ============================================================================
module lkc_store import lkc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  t_lkc_req         i_req,
    input  logic [CNT_W-1:0] i_limit,
    output t_lkc_res         o_res
);

    logic [CAPACITY-1:0] r_valid;
    logic [IDX_W-1:0]    r_rank [CAPACITY];
    logic [KEY_W-1:0]    r_key  [CAPACITY];
    logic [DATA_W-1:0]   r_data [CAPACITY];
    logic [CNT_W-1:0]    r_count;

    logic [CAPACITY-1:0] n_valid;
    logic [IDX_W-1:0]    n_rank [CAPACITY];
    logic [CNT_W-1:0]    n_count;

    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_tail;
    logic [CAPACITY-1:0] w_free;
    logic [CAPACITY-1:0] w_free_1h;
    logic [CAPACITY-1:0] w_new;
    logic [IDX_W-1:0]    w_hit_rank;
    logic [IDX_W-1:0]    w_tail_rank;
    logic                w_hit;
    logic                w_add;
    logic                w_rem;
    logic                w_clr;
    logic                w_ins;
    logic                w_evict;

    always_comb begin
        w_add = 1'b0;
        w_rem = 1'b0;
        w_clr = 1'b0;
        case (t_lkc_cmd'(i_req.cmd))
            CMD_ADD:    w_add = 1'b1;
            CMD_REMOVE: w_rem = 1'b1;
            CMD_CLEAR:  w_clr = 1'b1;
            default:    ;
        endcase

        w_tail_rank = IDX_W'(r_count - CNT_W'(1));
        w_hit_rank  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == i_req.key);
            w_tail[i]  = r_valid[i] && (r_rank[i] == w_tail_rank);
            w_hit_rank = w_hit_rank | (w_match[i] ? r_rank[i] : '0);
        end
        w_hit = |w_match;

        w_ins     = w_add && !w_hit;
        w_evict   = w_ins && (r_count >= i_limit);
        w_free    = ~r_valid;
        w_free_1h = w_free & (~w_free + CAPACITY'(1));
        w_new     = w_ins ? (w_evict ? w_tail : w_free_1h) : '0;

        for (int i = 0; i < CAPACITY; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (w_clr) begin
                n_valid[i] = 1'b0;
            end else if (w_add && w_hit) begin
                if (w_match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end else if (w_ins) begin
                if (w_new[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end else if (w_rem && w_hit) begin
                if (w_match[i]) begin
                    n_valid[i] = 1'b0;
                end else if (r_valid[i] && (r_rank[i] > w_hit_rank)) begin
                    n_rank[i] = r_rank[i] - IDX_W'(1);
                end
            end
        end

        n_count = r_count;
        if (w_clr) begin
            n_count = '0;
        end else if (w_ins) begin
            n_count = w_evict ? r_count : r_count + CNT_W'(1);
        end else if (w_rem && w_hit) begin
            n_count = r_count - CNT_W'(1);
        end

        o_res.ok      = w_ins || (w_rem && w_hit) || w_clr;
        o_res.evicted = w_evict;
        o_res.count   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_go) begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= n_rank[i];
                if (w_new[i]) begin
                    r_key[i]  <= i_req.key;
                    r_data[i] <= i_req.data;
                end
            end
        end
    end

endmodule

// ===== rtl/lru_key_cache_top.sv =====
// ============================================================================
// lru_key_cache_top: 16-entry key cache with least-recently-used eviction
// Request/response channels, APB register port, input and result registers.
// ============================================================================
// A request is held in an input register, checked against all 16 entries at
// once with its recency update, and its result is written to the output
// register once that is free or being emptied. One request per cycle is
// sustained while results are taken, the rate being set by the combinational
// parallel match and rank update of the entry store. A waiting result holds
// the input register and the store, and with it the request channel. There is no
// clearing pass after reset. Register max_entries sits at byte address 0.
module lru_key_cache_top import lkc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lkc_in_if.sink             i_req,
    lkc_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LIM_W-1:0] r_max_entries;
    logic             r_in_vld;
    t_lkc_req         r_in;
    logic             r_out_vld;
    t_lkc_res         r_out;

    logic             n_in_vld;
    logic             n_out_vld;
    logic             w_in_xfer;
    logic             w_adv;
    logic             w_reg_sel;
    logic [CNT_W-1:0] w_limit;
    t_lkc_res         w_res;

    assign w_reg_sel = (paddr[PADDR_W-1:2] == REG_MAX_ENTRIES);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? PDATA_W'(r_max_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= LIM_W'(CAPACITY);
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_max_entries <= pwdata[LIM_W-1:0];
        end
    end

    always_comb begin
        if (r_max_entries == '0) begin
            w_limit = CNT_W'(1);
        end else if (CNT_W'(r_max_entries) > CNT_W'(CAPACITY)) begin
            w_limit = CNT_W'(CAPACITY);
        end else begin
            w_limit = CNT_W'(r_max_entries);
        end
    end

    assign w_adv       = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_adv;
    assign w_in_xfer   = i_req.valid && i_req.ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_xfer) begin
            n_in_vld = 1'b1;
        end else if (w_adv) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.cmd  <= i_req.command;
            r_in.key  <= i_req.key;
            r_in.data <= i_req.data_value;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    lkc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_adv),
        .i_req   (r_in),
        .i_limit (w_limit),
        .o_res   (w_res)
    );

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.evicted     = r_out.evicted;
    assign o_rsp.entry_count = r_out.count;
    assign o_rsp.is_empty    = (r_out.count == '0);

endmodule

// ===== rtl/lkc_chk.sv =====
// ============================================================================
// lkc_chk: port-level checks of the LRU key cache
// Result consistency and response channel hold, attached to the top level.
// ============================================================================
module lkc_chk import lkc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_ok,
    input logic             i_evicted,
    input logic [CNT_W-1:0] i_count,
    input logic             i_is_empty
);

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_evict_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_evicted) |-> (i_ok && (i_count != '0)))
        else $error("eviction without a successful add");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_count) && $stable(i_ok) && $stable(i_evicted)))
        else $error("stalled result changed");

endmodule

bind lru_key_cache_top lkc_chk u_lkc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_ok        (o_rsp.ok),
    .i_evicted   (o_rsp.evicted),
    .i_count     (o_rsp.entry_count),
    .i_is_empty  (o_rsp.is_empty)
);

// ===== sim/lkc_scoreboard.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lkc_scoreboard: transfer monitor and scoreboard for the LRU key cache bench
// Tracks the cache contents and the entry limit from observed request
// transfers and register writes, predicts every result and compares it field
// by field with the oldest pending prediction; also checks register reads.
// ============================================================================
module lkc_scoreboard import lkc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lkc_in_if                  i_req,
    lkc_out_if                 i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_evictions
);

    typedef struct packed {
        logic             ok;
        logic             evicted;
        logic [CNT_W-1:0] count;
        logic             is_empty;
    } cache_result_t;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};

    logic [LIM_W-1:0]  limit_reg;
    logic              slot_valid [CAPACITY];
    logic [KEY_W-1:0]  slot_key   [CAPACITY];
    logic [DATA_W-1:0] slot_data  [CAPACITY];
    logic [IDX_W-1:0]  slot_rank  [CAPACITY];
    logic [CNT_W-1:0]  held;
    cache_result_t     expected_q [$];
    int                fail_count;
    int                checked;
    int                evictions;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_evictions  = evictions;

    function automatic logic [CNT_W-1:0] active_limit();
        if (limit_reg == '0) begin
            return CNT_W'(1);
        end
        if (limit_reg > CAPACITY) begin
            return CNT_W'(CAPACITY);
        end
        return CNT_W'(limit_reg);
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i] && slot_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // drop one entry and close the gap in the recency order
    function automatic void drop_slot(input int s);
        logic [IDX_W-1:0] gone;
        gone = slot_rank[s];
        slot_valid[s] = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i] && slot_rank[i] > gone) begin
                slot_rank[i]--;
            end
        end
        if (held != '0) begin
            held--;
        end
    endfunction

    function automatic cache_result_t predict_access(input logic [CMD_W-1:0] cmd,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [DATA_W-1:0] data);
        cache_result_t    res;
        int               hit;
        int               victim;
        int               spot;
        logic [IDX_W-1:0] pos;
        res = '0;
        hit = find_slot(key);
        case (cmd)
            CMD_ADD: begin
                if (hit >= 0) begin
                    pos = slot_rank[hit];
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_valid[i] && slot_rank[i] < pos) begin
                            slot_rank[i]++;
                        end
                    end
                    slot_rank[hit] = '0;
                end else begin
                    if (held >= active_limit() && held != '0) begin
                        victim = -1;
                        for (int i = CAPACITY - 1; i >= 0; i--) begin
                            if (slot_valid[i] && CNT_W'(slot_rank[i]) == held - 1'b1) begin
                                victim = i;
                            end
                        end
                        if (victim >= 0) begin
                            drop_slot(victim);
                            res.evicted = 1'b1;
                            evictions++;
                        end
                    end
                    spot = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) begin
                            spot = i;
                        end
                    end
                    if (spot >= 0) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (slot_valid[i]) begin
                                slot_rank[i]++;
                            end
                        end
                        slot_valid[spot] = 1'b1;
                        slot_key[spot]   = key;
                        slot_data[spot]  = data;
                        slot_rank[spot]  = '0;
                        held++;
                        res.ok = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    drop_slot(hit);
                    res.ok = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    slot_valid[i] = 1'b0;
                end
                held   = '0;
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.count    = held;
        res.is_empty = (held == '0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        cache_result_t seen;
        cache_result_t want;
        if (!i_rst_n) begin
            limit_reg = LIM_W'(CAPACITY);
            for (int i = 0; i < CAPACITY; i++) begin
                slot_valid[i] = 1'b0;
            end
            held = '0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == LIMIT_ADDR) begin
                if (i_pwrite) begin
                    limit_reg = i_pwdata[LIM_W-1:0];
                end else if (i_prdata !== PDATA_W'(limit_reg)) begin
                    $display("%0t ns: max_entries read: expected %0d, actual %0d",
                             $time, limit_reg, i_prdata);
                    fail_count++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(predict_access(i_req.command, i_req.key,
                                                    i_req.data_value));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                seen = {i_rsp.ok, i_rsp.evicted, i_rsp.entry_count, i_rsp.is_empty};
                if (expected_q.size() == 0) begin
                    $display("%0t ns: result with none expected: ok=%0b evicted=%0b count=%0d empty=%0b",
                             $time, seen.ok, seen.evicted, seen.count, seen.is_empty);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (seen !== want) begin
                        $display("%0t ns: result %0d: expected ok=%0b evicted=%0b count=%0d empty=%0b",
                                 $time, checked, want.ok, want.evicted, want.count,
                                 want.is_empty);
                        $display("%0t ns: result %0d: actual   ok=%0b evicted=%0b count=%0d empty=%0b",
                                 $time, checked, seen.ok, seen.evicted, seen.count,
                                 seen.is_empty);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// ===== sim/lru_key_cache_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lru_key_cache_top_tb: testbench top of the LRU key cache
// Drives directed and random request sequences across several entry limits,
// with random idle bursts on both channels in most phases, and reports the verdict of the
// scoreboard that watches the transfers beside the block.
// ============================================================================
module lru_key_cache_top_tb import lkc_pkg::*; ();

    localparam logic [PADDR_W-1:0] LIMIT_ADDR   = {REG_MAX_ENTRIES, 2'b00};
    localparam logic [CMD_W-1:0]   CMD_RESERVED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               gaps_on;
    logic               stalls_on;
    int                 stall_left;
    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 evictions;
    int                 sent;
    int                 settings;

    lkc_in_if  req_if ();
    lkc_out_if rsp_if ();

    lru_key_cache_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lkc_scoreboard u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_evictions  (evictions)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!stalls_on) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 7);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] data);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.key        <= key;
        req_if.data_value <= data;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent++;
    endtask

    task automatic apb_access(input logic write, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LIMIT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input int value);
        drain();
        apb_access(1'b1, PDATA_W'(value));
        apb_access(1'b0, '0);
        settings++;
    endtask

    task automatic run_phase(input int lim_value, input int n_items, input logic idle);
        int                eff;
        int                pool_n;
        int                roll;
        int                rm_pct;
        logic [KEY_W-1:0]  pool [$];
        logic [KEY_W-1:0]  key;
        logic [CMD_W-1:0]  cmd;
        set_limit(lim_value);
        gaps_on   <= idle;
        stalls_on <= idle;
        eff = (lim_value < 1) ? 1 : ((lim_value > CAPACITY) ? CAPACITY : lim_value);
        pool_n = eff + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++) begin
            pool.push_back($urandom);
        end
        pool[0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        rm_pct = $urandom_range(10, 30);
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                cmd = CMD_CLEAR;
            end else if (roll < 4) begin
                cmd = CMD_RESERVED;
            end else if (roll < 4 + rm_pct) begin
                cmd = CMD_REMOVE;
            end else begin
                cmd = CMD_ADD;
            end
            if ($urandom_range(0, 99) < 85) begin
                key = pool[$urandom_range(0, pool_n - 1)];
            end else begin
                key = $urandom;
            end
            send_request(cmd, key, $urandom);
        end
    endtask

    initial begin
        int   limits [10];
        logic idles [10];
        limits            = '{16, 3, 1, 8, 0, 17, 5, 31, 2, 16};
        idles             = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_if.valid      <= 1'b0;
        req_if.command    <= CMD_ADD;
        req_if.key        <= '0;
        req_if.data_value <= '0;
        gaps_on           <= 1'b1;
        stalls_on         <= 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, '0);

        send_request(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0005, 32'hFFFF_FFFF);
        send_request(CMD_RESERVED, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_ADD, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ADD, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(CMD_ADD, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_request(CMD_ADD, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_RESERVED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ADD, 32'h1234_5678, 32'hDEAD_BEEF);
        // lower the limit below the current count
        set_limit(1);
        send_request(CMD_ADD, 32'h0000_0001, 32'h0000_0011);
        send_request(CMD_ADD, 32'h0000_0001, 32'h0000_0022);
        send_request(CMD_ADD, 32'h0000_0002, 32'h0000_0033);
        set_limit(0);
        send_request(CMD_ADD, 32'h0000_0003, 32'h0000_0044);
        set_limit(31);
        send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_limit(2);
        send_request(CMD_ADD, 32'h0000_000A, 32'h0000_0001);
        send_request(CMD_ADD, 32'h0000_0014, 32'h0000_0002);
        send_request(CMD_ADD, 32'h0000_000A, 32'h0000_0003);
        send_request(CMD_ADD, 32'h0000_001E, 32'h0000_0004);
        send_request(CMD_REMOVE, 32'h0000_0014, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_000A, 32'h0000_0000);
        send_request(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < 10; p++) begin
            run_phase(limits[p], 93, idles[p]);
        end
        drain();

        $display("Covered %0d requests over %0d limit settings with idle bursts on both sides;",
                 sent, settings);
        $display("%0d results compared, %0d evictions predicted.", checked, evictions);
        if (pending != 0) begin
            $display("%0d predicted results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("lru_key_cache_top: match");
        end else begin
            $display("lru_key_cache_top: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("lru_key_cache_top: mismatch");
        $finish;
    end

endmodule
